FILE: rtl/core/paged_list_allocator_unit_defines.svh
// Assertion helper macros used by the allocator unit.
`ifndef PAGED_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGED_LIST_ALLOCATOR_UNIT_DEFINES_SVH
// Implication checked every clock outside reset.
`define PLA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Types and constants of the paged list allocator.
// ----------------------------------------------------------------------------
package pla_pkg;
    localparam int PAGE_ELEMS  = 16;
    localparam int PAGE_COUNT  = 64;
    localparam int NUM_SLOTS   = 16;
    localparam int DATA_BITS   = 32;
    localparam int STORE_DEPTH = PAGE_COUNT * PAGE_ELEMS;
    localparam int MAP_DEPTH   = NUM_SLOTS * PAGE_COUNT;
    localparam int PG_W   = $clog2(PAGE_COUNT);
    localparam int OFF_W  = (PAGE_ELEMS > 1) ? $clog2(PAGE_ELEMS) : 1;
    localparam int SL_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(PAGE_COUNT + 1);
    localparam int SA_W   = $clog2(STORE_DEPTH);
    localparam int MA_W   = $clog2(MAP_DEPTH);

    typedef enum logic [1:0] {
        FN_CREATE = 2'd0, FN_WRITE = 2'd1, FN_READ = 2'd2, FN_FREE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NO_SPACE = 3'd1, ST_NO_LIST = 3'd2,
        ST_BAD_INDEX = 3'd3, ST_IN_USE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_CREATE, S_FREE_RD, S_FREE_WR, S_ACC_MAP, S_ACC_RD, S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         list_id;
        logic [10:0]        elem_count;
        logic [9:0]         elem_index;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_value;
    } rsp_t;
endpackage

FILE: rtl/core/pla_store.sv
// ----------------------------------------------------------------------------
// pla_store
// Element store: one synchronous port, registered read data.
// ----------------------------------------------------------------------------
module pla_store
    import pla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic                 we,
    input  logic [SA_W-1:0]      addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);
    logic [DATA_BITS-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end
endmodule

FILE: rtl/core/paged_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// paged_list_allocator_unit
// Paged list allocator with a FIFO of free pages.
// ----------------------------------------------------------------------------
// One request at a time. After reset an initialisation pass writes every page
// number into the free page queue before the first request is taken. A read
// or write passes through a page map read, a store access and the reply; a
// create checks the request and then moves one page per step; a free reads
// the map and writes the queue for each page. An error ends the operation in
// its first state. The response must be taken before the next request is
// accepted. The single-port page map and store memories set the pace.
`include "paged_list_allocator_unit_defines.svh"
module paged_list_allocator_unit
    import pla_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);
    logic [PG_W-1:0] fq_mem [PAGE_COUNT];
    logic [PG_W-1:0] map_mem [MAP_DEPTH];
    logic [PG_W-1:0] fq_q, map_q;

    state_t state_reg, state_next;
    req_t req_reg, req_next;
    logic [PG_W-1:0] head_reg, head_next, tail_reg, tail_next, ptr_reg, ptr_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next, n_reg, n_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [10:0] size_reg [NUM_SLOTS];
    logic [10:0] size_wdata;
    logic size_we;
    logic out_v_reg, out_v_next;
    rsp_t out_reg, out_next;

    logic fq_we, map_we, st_en, st_we;
    logic [PG_W-1:0] fq_addr, fq_wdata, map_wdata;
    logic [MA_W-1:0] map_addr;
    logic [SA_W-1:0] st_addr;
    logic [DATA_BITS-1:0] st_rdata;

    logic [SL_W-1:0] sl;
    logic slot_ok, sv;
    logic [10:0] sz;
    logic [11:0] pages_w;

    assign sl      = req_reg.list_id[SL_W-1:0];
    assign slot_ok = 32'(req_reg.list_id) < NUM_SLOTS;
    assign sv      = valid_reg[sl];
    assign sz      = size_reg[sl];

    always_ff @(posedge aclk) begin
        if (fq_we) fq_mem[fq_addr] <= fq_wdata;
        fq_q <= fq_mem[fq_addr];
        if (map_we) map_mem[map_addr] <= map_wdata;
        map_q <= map_mem[map_addr];
        if (size_we) size_reg[sl] <= size_wdata;
    end

    pla_store u_store (
        .aclk(aclk), .en(st_en), .we(st_we), .addr(st_addr),
        .wdata(req_reg.write_value[DATA_BITS-1:0]), .rdata(st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            head_reg  <= '0;
            tail_reg  <= '0;
            ptr_reg   <= '0;
            fcnt_reg  <= CNT_W'(PAGE_COUNT);
            n_reg     <= '0;
            valid_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ptr_reg   <= ptr_next;
            fcnt_reg  <= fcnt_next;
            n_reg     <= n_next;
            valid_reg <= valid_next;
            out_v_reg <= out_v_next;
        end
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        ptr_next   = ptr_reg;
        fcnt_next  = fcnt_reg;
        n_next     = n_reg;
        valid_next = valid_reg;
        out_v_next = out_v_reg && !m_ready;
        out_next   = out_reg;
        fq_we = 1'b0; fq_addr = head_reg; fq_wdata = ptr_reg;
        map_we = 1'b0; map_addr = '0; map_wdata = fq_q;
        st_en = 1'b0; st_we = 1'b0; st_addr = '0;
        size_we = 1'b0; size_wdata = req_reg.elem_count;
        pages_w = (12'(req_reg.elem_count) + 12'(PAGE_ELEMS - 1)) >> $clog2(PAGE_ELEMS);
        unique case (state_reg)
            S_INIT: begin
                fq_we = 1'b1; fq_addr = ptr_reg; fq_wdata = ptr_reg;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == PG_W'(PAGE_COUNT - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next   = s_data;
                    state_next = S_DONE;
                    if (s_data.func == FN_CREATE) state_next = S_CREATE;
                    if (s_data.func == FN_FREE)   state_next = S_FREE_RD;
                    if (s_data.func == FN_WRITE || s_data.func == FN_READ)
                        state_next = S_ACC_MAP;
                    ptr_next = '0;
                end
            end
            S_CREATE: begin
                // first cycle: check; later cycles: move one page per cycle
                if (n_reg == '0 && ptr_reg == '0) begin
                    out_next = '{status: ST_OK, read_value: '0};
                    if (!slot_ok) out_next.status = ST_NO_LIST;
                    else if (sv) out_next.status = ST_IN_USE;
                    else if (req_reg.elem_count == '0 ||
                             32'(req_reg.elem_count) > STORE_DEPTH)
                        out_next.status = ST_BAD_INDEX;
                    else if (32'(pages_w) > 32'(fcnt_reg)) out_next.status = ST_NO_SPACE;
                    if (out_next.status != ST_OK) begin
                        out_v_next = 1'b1; state_next = S_IDLE;
                    end else begin
                        n_next = CNT_W'(pages_w);
                        fq_addr = head_reg;
                    end
                end else begin
                    map_we = 1'b1;
                    map_addr = MA_W'({sl, ptr_reg});
                    head_next = head_reg + 1'b1;
                    fq_addr = head_next;
                    fcnt_next = fcnt_reg - 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                    if (CNT_W'(ptr_reg) + 1'b1 == n_reg) begin
                        valid_next[sl] = 1'b1; size_we = 1'b1;
                        n_next = '0; ptr_next = '0;
                        out_v_next = 1'b1; state_next = S_IDLE;
                    end
                end
            end
            S_FREE_RD: begin
                if (!slot_ok || !sv) begin
                    out_next = '{status: ST_NO_LIST, read_value: '0};
                    out_v_next = 1'b1; state_next = S_IDLE;
                end else if (CNT_W'(ptr_reg) == CNT_W'((12'(sz) + 12'(PAGE_ELEMS - 1))
                                                  >> $clog2(PAGE_ELEMS))
                             || 32'(ptr_reg) >= PAGE_COUNT
                             || fcnt_reg == CNT_W'(PAGE_COUNT)
                             || (ptr_reg == '0 && n_reg != '0)) begin
                    valid_next[sl] = 1'b0; size_we = 1'b1; size_wdata = '0;
                    out_next = '{status: ST_OK, read_value: '0};
                    n_next = '0; ptr_next = '0;
                    out_v_next = 1'b1; state_next = S_IDLE;
                end else begin
                    map_addr = MA_W'({sl, ptr_reg});
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                fq_we = 1'b1; fq_addr = tail_reg; fq_wdata = map_q;
                tail_next = tail_reg + 1'b1;
                fcnt_next = fcnt_reg + 1'b1;
                ptr_next = ptr_reg + 1'b1;
                n_next = CNT_W'(1);
                state_next = S_FREE_RD;
            end
            S_ACC_MAP: begin
                if (!slot_ok || !sv) begin
                    out_next = '{status: ST_NO_LIST, read_value: '0};
                    out_v_next = 1'b1; state_next = S_IDLE;
                end else if (11'(req_reg.elem_index) >= sz) begin
                    out_next = '{status: ST_BAD_INDEX, read_value: '0};
                    out_v_next = 1'b1; state_next = S_IDLE;
                end else begin
                    map_addr = MA_W'({sl, PG_W'(req_reg.elem_index >> $clog2(PAGE_ELEMS))});
                    state_next = S_ACC_RD;
                end
            end
            S_ACC_RD: begin
                st_en = 1'b1;
                st_we = (req_reg.func == FN_WRITE);
                st_addr = SA_W'({map_q, OFF_W'(req_reg.elem_index)});
                state_next = S_DONE;
            end
            S_DONE: begin
                out_next = '{status: ST_OK, read_value: '0};
                if (!slot_ok) out_next.status = ST_NO_LIST;
                else if (req_reg.func == FN_READ)
                    out_next.read_value = 32'(signed'(st_rdata));
                out_v_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `PLA_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, 32'(fcnt_reg) <= PAGE_COUNT)
    `PLA_ASSERT_NXT(a_one_out, aclk, aresetn, s_valid && s_ready, !m_valid)
    `PLA_ASSERT_IMP(a_no_take_busy, aclk, aresetn, m_valid, !s_ready)
endmodule

FILE: bench/pla_checker.sv
// ----------------------------------------------------------------------------
// pla_checker
// Watches the request and response channels of the paged list allocator,
// tracks pages, slots and element data, and compares every response with
// the predicted one in request order.
// ----------------------------------------------------------------------------
module pla_checker
    import pla_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  rsp_t m_data,
    output int   fail_count,
    output int   pending,
    output int   resp_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PG_W-1:0]      free_pages [PAGE_COUNT];
    logic [PG_W-1:0]      pg_head;
    logic [PG_W-1:0]      pg_tail;
    int                   pg_avail;
    logic                 in_use [NUM_SLOTS];
    logic [10:0]          list_len [NUM_SLOTS];
    logic [PG_W-1:0]      list_pages [NUM_SLOTS][PAGE_COUNT];
    logic signed [31:0]   cells [STORE_DEPTH];
    rsp_t                 expected_rsp [$];

    initial begin
        for (int i = 0; i < PAGE_COUNT; i++) free_pages[i] = PG_W'(i);
        pg_head = '0;
        pg_tail = '0;
        pg_avail = PAGE_COUNT;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            in_use[i] = 1'b0;
            list_len[i] = '0;
        end
        fail_count = 0;
        pending = 0;
        resp_seen = 0;
    end

    function automatic int cell_addr(int sl, int idx);
        return int'(list_pages[sl][idx / PAGE_ELEMS]) * PAGE_ELEMS + idx % PAGE_ELEMS;
    endfunction

    function automatic rsp_t allocate_step(req_t r);
        rsp_t o;
        int sl;
        int npg;
        o.status = ST_OK;
        o.read_value = '0;
        sl = int'(r.list_id);
        npg = (int'(r.elem_count) + PAGE_ELEMS - 1) / PAGE_ELEMS;
        if (sl >= NUM_SLOTS) begin
            o.status = ST_NO_LIST;
        end else begin
            case (func_t'(r.func))
                FN_CREATE: begin
                    if (in_use[sl]) o.status = ST_IN_USE;
                    else if (r.elem_count == 0 || r.elem_count > STORE_DEPTH)
                        o.status = ST_BAD_INDEX;
                    else if (npg > pg_avail) o.status = ST_NO_SPACE;
                    else begin
                        for (int i = 0; i < npg; i++) begin
                            list_pages[sl][i] = free_pages[pg_head];
                            pg_head++;
                            pg_avail--;
                        end
                        in_use[sl] = 1'b1;
                        list_len[sl] = r.elem_count;
                    end
                end
                FN_WRITE, FN_READ: begin
                    if (!in_use[sl]) o.status = ST_NO_LIST;
                    else if (r.elem_index >= list_len[sl]) o.status = ST_BAD_INDEX;
                    else if (r.func == FN_WRITE)
                        cells[cell_addr(sl, int'(r.elem_index))] = r.write_value;
                    else o.read_value = cells[cell_addr(sl, int'(r.elem_index))];
                end
                default: begin
                    if (!in_use[sl]) o.status = ST_NO_LIST;
                    else begin
                        npg = (int'(list_len[sl]) + PAGE_ELEMS - 1) / PAGE_ELEMS;
                        for (int i = 0; i < npg && pg_avail < PAGE_COUNT; i++) begin
                            free_pages[pg_tail] = list_pages[sl][i];
                            pg_tail++;
                            pg_avail++;
                        end
                        in_use[sl] = 1'b0;
                        list_len[sl] = '0;
                    end
                end
            endcase
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        int errs;
        errs = 0;
        if (aresetn && m_valid && m_ready) begin
            resp_seen <= resp_seen + 1;
            if (expected_rsp.size() == 0) begin
                $error("response with no request outstanding");
                errs++;
            end else begin
                want = expected_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_data.status);
                    errs++;
                end
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value expected %0d actual %0d",
                           want.read_value, m_data.read_value);
                    errs++;
                end
            end
        end
        if (errs != 0) fail_count <= fail_count + errs;
        if (aresetn && s_valid && s_ready)
            expected_rsp.insert(expected_rsp.size(), allocate_step(s_data));
        pending <= expected_rsp.size();
    end
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives create, write, read and free requests into the paged list allocator
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench
    import pla_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 900000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    int   fail_count;
    int   pending;
    int   resp_seen;
    int   src_idle = 0;
    int   snk_idle = 0;
    bit   snk_hold = 1'b0;
    int   cycles = 0;
    int   sent = 0;
    int   avail = PAGE_COUNT;
    bit   live [NUM_SLOTS];
    int   live_len [NUM_SLOTS];
    bit   written [NUM_SLOTS][1024];

    paged_list_allocator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    pla_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .resp_seen(resp_seen)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (snk_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= snk_idle);
    end

    task automatic send(req_t r);
        int npg;
        npg = (int'(r.elem_count) + PAGE_ELEMS - 1) / PAGE_ELEMS;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (r.list_id < NUM_SLOTS) begin
            if (r.func == FN_CREATE && !live[r.list_id] && r.elem_count != 0
                && r.elem_count <= STORE_DEPTH && npg <= avail) begin
                live[r.list_id] = 1'b1;
                live_len[r.list_id] = r.elem_count;
                avail -= npg;
                for (int i = 0; i < 1024; i++) written[r.list_id][i] = 1'b0;
            end else if (r.func == FN_WRITE && live[r.list_id]
                         && r.elem_index < live_len[r.list_id]) begin
                written[r.list_id][r.elem_index] = 1'b1;
            end else if (r.func == FN_FREE && live[r.list_id]) begin
                avail += (live_len[r.list_id] + PAGE_ELEMS - 1) / PAGE_ELEMS;
                live[r.list_id] = 1'b0;
            end
        end
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0 || resp_seen != sent) @(negedge aclk);
    endtask

    function automatic req_t mk(func_t f, int sl, int cnt, int idx, logic [31:0] v);
        req_t r;
        r.func = f;
        r.list_id = 4'(sl);
        r.elem_count = 11'(cnt);
        r.elem_index = 10'(idx);
        r.write_value = v;
        return r;
    endfunction

    // create on used slot changes nothing if successful creates were tracked;
    // in-range reads on a live list are only issued on written elements
    function automatic req_t pick_random();
        req_t r;
        int sl;
        int p;
        int idx;
        r = req_t'($bits(req_t)'({$urandom, $urandom}));
        sl = $urandom_range(NUM_SLOTS - 1);
        r.list_id = 4'(sl);
        p = $urandom_range(99);
        if (p < 12) begin
            r.func = FN_CREATE;
            r.elem_count = ($urandom_range(9) == 0) ? 11'($urandom_range(1100))
                                                     : 11'($urandom_range(1, 80));
        end else if (p < 20) begin
            r.func = FN_FREE;
        end else if (p < 55) begin
            r.func = FN_WRITE;
            if (live[sl] && $urandom_range(9) != 0)
                r.elem_index = 10'($urandom_range(live_len[sl] - 1));
        end else begin
            r.func = FN_READ;
            if (live[sl]) begin
                idx = $urandom_range(live_len[sl] - 1);
                if (!written[sl][idx] || $urandom_range(9) == 0) begin
                    if ($urandom_range(1)) idx = live_len[sl] + $urandom_range(50);
                    else r.func = FN_WRITE;
                end
                if (idx > 1023) idx = 1023;
                r.elem_index = 10'(idx);
                if (r.func == FN_READ && idx < live_len[sl] && !written[sl][idx])
                    r.func = FN_WRITE;
            end
        end
        return r;
    endfunction

    initial begin
        int hold;
        for (int i = 0; i < NUM_SLOTS; i++) live[i] = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send(mk(FN_READ, 3, 0, 0, '0));
        send(mk(FN_FREE, 3, 0, 0, '0));
        send(mk(FN_CREATE, 0, 0, 0, '0));
        send(mk(FN_CREATE, 0, 1025, 0, '0));
        send(mk(FN_CREATE, 0, 2047, 0, '0));
        send(mk(FN_CREATE, 0, 1024, 0, '0));
        send(mk(FN_CREATE, 0, 5, 0, '0));
        send(mk(FN_CREATE, 1, 1, 0, '0));
        send(mk(FN_WRITE, 0, 0, 0, 32'h8000_0000));
        send(mk(FN_WRITE, 0, 0, 1023, 32'h7fff_ffff));
        send(mk(FN_WRITE, 0, 0, 1024 - 1, 32'hffff_ffff));
        send(mk(FN_READ, 0, 0, 0, '0));
        send(mk(FN_READ, 0, 0, 1023, '0));
        send(mk(FN_READ, 0, 2047, 0, 32'h5555_aaaa));
        send(mk(FN_FREE, 0, 0, 0, '0));
        send(mk(FN_READ, 0, 0, 0, '0));
        send(mk(FN_CREATE, 2, 17, 0, '0));
        send(mk(FN_WRITE, 2, 0, 16, 32'h1234_5678));
        send(mk(FN_WRITE, 2, 0, 17, '0));
        send(mk(FN_READ, 2, 0, 16, '0));
        send(mk(FN_FREE, 2, 0, 0, '0));
        send(mk(FN_FREE, 2, 0, 0, '0));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 18 : (ph == 1) ? 52 : 0;
            snk_idle = (ph == 0) ? 52 : (ph == 1) ? 18 : 0;
            if (ph == 1) begin
                fork
                    begin
                        snk_hold = 1'b1;
                        hold = 0;
                        while (hold < 300) begin
                            @(posedge aclk);
                            hold++;
                        end
                        snk_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 645; n++) send(pick_random());
            drain();
        end

        repeat (60) @(posedge aclk);
        $display("covered %0d requests over three idling phases with a long response stall",
                 sent);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pla_pkg.sv
rtl/core/pla_store.sv
rtl/core/paged_list_allocator_unit.sv
bench/pla_checker.sv
bench/testbench.sv
